// File: hw/rtl/sliding_window_slope_estimator_defines.svh
// Assertion macros shared by the RTL.
`ifndef SLIDING_WINDOW_SLOPE_ESTIMATOR_DEFINES_SVH
`define SLIDING_WINDOW_SLOPE_ESTIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent holds -> consequent holds in the same cycle.
`define SWSE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Antecedent holds -> consequent holds in the next cycle.
`define SWSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SWSE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SWSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/swse_pkg.sv
package swse_pkg;

    localparam int SENSOR_W = 4;
    localparam int TEMP_W   = 20;
    localparam int RATE_W   = 40;
    localparam int COUNT_W  = 5;

    localparam int SENSORS_DEF     = 16;
    localparam int HISTORY_MAX_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // slope*60 with x = -5*i: 60 * 5 / 25 folds to one small factor
    localparam int RATE_SCALE    = 60;
    localparam int TIME_STEP_MAG = 5;
    localparam int RATE_FACTOR   = RATE_SCALE * TIME_STEP_MAG / (TIME_STEP_MAG * TIME_STEP_MAG);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: hw/rtl/sliding_window_slope_estimator.sv
// Per-sensor least-squares rise-rate estimator. Each input beat carries one
// temperature sample for one sensor; the block stores it in a per-sensor ring
// held in a single synchronous sample memory and, once the window of the last
// N = min(history_count, HISTORY_MAX) samples is full, returns the slope of
// temperature against time (sample i at time -5*i) times 60, in signed fixed
// point with FRAC_BITS fraction bits, truncated toward zero and saturated to
// 40 bits. Exactly one result beat follows every input beat; rate_valid is low
// and rise_rate is zero when history_count is 0 or 1 (nothing stored), when the
// window is not yet full, or when sensor is out of range. One item is in work
// at a time: a full-window item is accepted, streams its window out of the
// sample memory, forms numerator and denominator, runs the bit-serial divider
// (DVD_W is 49 at the defaults) and loads the output register; an item that
// gives no rate goes from the accept straight to the output register. Output
// stalls hold up an item only when a result is still waiting as the next one
// is ready. The output register lets the next beat in while a result waits.
// Write history_count only while the block is idle.
`include "sliding_window_slope_estimator_defines.svh"

module sliding_window_slope_estimator #(
    parameter int SENSORS     = swse_pkg::SENSORS_DEF,
    parameter int HISTORY_MAX = swse_pkg::HISTORY_MAX_DEF,
    parameter int FRAC_BITS   = swse_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                history_count_we,
    input  logic [swse_pkg::COUNT_W-1:0]        history_count,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [swse_pkg::SENSOR_W-1:0]       sensor,
    input  logic signed [swse_pkg::TEMP_W-1:0]  temperature,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [swse_pkg::SENSOR_W-1:0]       sensor_out,
    output logic signed [swse_pkg::RATE_W-1:0]  rise_rate,
    output logic                                rate_valid
);

    localparam int TEMP_W = swse_pkg::TEMP_W;
    localparam int RATE_W = swse_pkg::RATE_W;
    localparam int SID_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int IW     = $clog2(HISTORY_MAX);
    localparam int NW     = $clog2(HISTORY_MAX + 1);
    localparam int DEPTH  = SENSORS * HISTORY_MAX;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SI_W   = 2 * NW;
    localparam int SII_W  = 3 * NW;
    localparam int SY_W   = TEMP_W + NW;
    localparam int SIY_W  = TEMP_W + 2 * NW;
    localparam int A_W    = TEMP_W + 3 * NW + 2;
    localparam int B_W    = 4 * NW;
    localparam int F_W    = $clog2(swse_pkg::RATE_FACTOR + 1);
    localparam int M_W    = A_W + F_W;
    localparam int DVD_W  = M_W + FRAC_BITS;
    localparam logic [63:0] LIM_POS = (64'd1 << (RATE_W - 1)) - 64'd1;
    localparam logic [63:0] LIM_NEG = 64'd1 << (RATE_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MUL,
        S_SUB,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [swse_pkg::COUNT_W-1:0] hc_reg;
    logic [NW-1:0]                fill_reg [SENSORS];
    logic [IW-1:0]                slot_reg [SENSORS];

    // item context
    logic [swse_pkg::SENSOR_W-1:0] sensor_reg;
    logic [NW-1:0]                 n_reg;
    logic [IW-1:0]                 rd_slot_reg;
    logic [NW-1:0]                 issue_reg;
    logic                          pend_reg;
    logic [IW-1:0]                 pend_i_reg;

    // window sums
    logic [SI_W-1:0]          si_reg;
    logic [SII_W-1:0]         sii_reg;
    logic signed [SY_W-1:0]   sy_reg;
    logic signed [SIY_W-1:0]  siy_reg;

    logic signed [A_W-1:0]    p1_reg;
    logic signed [A_W-1:0]    p2_reg;
    logic [B_W-1:0]           p3_reg;
    logic [B_W-1:0]           p4_reg;
    logic                     neg_reg;

    logic                     res_valid_reg;
    logic signed [RATE_W-1:0] res_rate_reg;

    logic                          out_valid_reg;
    logic [swse_pkg::SENSOR_W-1:0] sensor_out_reg;
    logic signed [RATE_W-1:0]      rise_rate_reg;
    logic                          rate_valid_reg;

    // accept-side decode
    logic              in_take;
    logic [SID_W-1:0]  in_sid;
    logic              in_range;
    logic              track_on;
    logic [NW-1:0]     n_in;
    logic [NW-1:0]     fill_cur;
    logic [IW-1:0]     slot_cur;
    logic [IW-1:0]     slot_new;
    logic [NW-1:0]     fill_new;
    logic              do_store;

    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [AW-1:0]     mem_wr_addr;
    logic [TEMP_W-1:0] mem_rd_data;

    logic signed [IW+TEMP_W:0]     iy_prod;
    logic signed [A_W-1:0]         a_val;
    logic [B_W-1:0]                b_val;
    logic [A_W-1:0]                a_mag;
    logic [M_W-1:0]                a_scaled;
    logic                          div_start;
    logic [DVD_W-1:0]              div_dividend;
    logic [DVD_W-1:0]              div_quotient;
    swse_pkg::div_status_t         div_st;
    logic [63:0]                   q_ext;
    logic [63:0]                   q_sat;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_sid   = SID_W'(sensor);
        in_range = (32'(sensor) < SENSORS);
        track_on = (hc_reg > swse_pkg::COUNT_W'(1));
        if (32'(hc_reg) > HISTORY_MAX)
        begin
            n_in = NW'(HISTORY_MAX);
        end
        else
        begin
            n_in = NW'(hc_reg);
        end
        fill_cur = fill_reg[in_sid];
        slot_cur = slot_reg[in_sid];
        slot_new = (32'(slot_cur) == HISTORY_MAX - 1) ? '0 : slot_cur + 1'b1;
        fill_new = (fill_cur < n_in) ? fill_cur + 1'b1 : n_in;
        do_store = in_take && in_range && track_on;
        mem_wr_addr = AW'(32'(in_sid) * HISTORY_MAX + 32'(slot_new));
    end

    always_comb
    begin
        mem_rd_en   = (state_reg == S_ACC) && (issue_reg < n_reg);
        mem_rd_addr = AW'(32'(SID_W'(sensor_reg)) * HISTORY_MAX + 32'(rd_slot_reg));
        iy_prod     = $signed({1'b0, pend_i_reg}) * $signed(mem_rd_data);
        a_val       = p1_reg - p2_reg;
        b_val       = p3_reg - p4_reg;
        a_mag       = a_val[A_W-1] ? A_W'(-a_val) : A_W'(a_val);
        a_scaled    = M_W'(a_mag) * F_W'(swse_pkg::RATE_FACTOR);
        div_dividend = DVD_W'(a_scaled) << FRAC_BITS;
        div_start   = (state_reg == S_SUB) && (b_val != '0);
        q_ext       = 64'(div_quotient);
        if (neg_reg)
        begin
            q_sat = (q_ext > LIM_NEG) ? LIM_NEG : q_ext;
            q_sat = 64'd0 - q_sat;
        end
        else
        begin
            q_sat = (q_ext > LIM_POS) ? LIM_POS : q_ext;
        end
    end

    swse_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (TEMP_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (do_store),
        .wr_addr (mem_wr_addr),
        .wr_data (temperature),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    swse_div #(
        .DVD_W (DVD_W),
        .DVS_W (B_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (b_val),
        .quotient (div_quotient),
        .status   (div_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hc_reg        <= '0;
            pend_reg      <= 1'b0;
            issue_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SENSORS; k++)
            begin
                fill_reg[k] <= '0;
                slot_reg[k] <= '0;
            end
        end
        else
        begin
            if (history_count_we)
            begin
                hc_reg <= history_count;
            end

            // drop the output beat once taken, unless the next one replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        sensor_reg    <= sensor;
                        n_reg         <= n_in;
                        rd_slot_reg   <= slot_new;
                        issue_reg     <= '0;
                        pend_reg      <= 1'b0;
                        si_reg        <= '0;
                        sii_reg       <= '0;
                        sy_reg        <= '0;
                        siy_reg       <= '0;
                        res_valid_reg <= 1'b0;
                        res_rate_reg  <= '0;
                        if (do_store)
                        begin
                            slot_reg[in_sid] <= slot_new;
                            fill_reg[in_sid] <= fill_new;
                        end
                        // full window: stream it out of memory, else report at once
                        if (do_store && (fill_new >= n_in))
                        begin
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end

                S_ACC:
                begin
                    if (mem_rd_en)
                    begin
                        rd_slot_reg <= (rd_slot_reg == '0) ? IW'(HISTORY_MAX - 1)
                                                           : rd_slot_reg - 1'b1;
                        issue_reg   <= issue_reg + 1'b1;
                        pend_i_reg  <= issue_reg[IW-1:0];
                    end
                    pend_reg <= mem_rd_en;
                    if (pend_reg)
                    begin
                        si_reg  <= si_reg + SI_W'(pend_i_reg);
                        sii_reg <= sii_reg + SII_W'(pend_i_reg) * pend_i_reg;
                        sy_reg  <= sy_reg + SY_W'($signed(mem_rd_data));
                        siy_reg <= siy_reg + SIY_W'(iy_prod);
                    end
                    if (!mem_rd_en && !pend_reg)
                    begin
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    p1_reg    <= $signed({1'b0, n_reg}) * A_W'(siy_reg);
                    p2_reg    <= $signed({1'b0, si_reg}) * A_W'(sy_reg);
                    p3_reg    <= n_reg * B_W'(sii_reg);
                    p4_reg    <= si_reg * B_W'(si_reg);
                    state_reg <= S_SUB;
                end

                S_SUB:
                begin
                    // time runs backward, so a rising sum of i*y means a falling slope
                    neg_reg <= (a_val > 0);
                    if (b_val != '0)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end

                S_DIV:
                begin
                    if (div_st.done)
                    begin
                        res_rate_reg  <= q_sat[RATE_W-1:0];
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        sensor_out_reg <= sensor_reg;
                        rise_rate_reg  <= res_rate_reg;
                        rate_valid_reg <= res_valid_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign sensor_out = sensor_out_reg;
    assign rise_rate  = rise_rate_reg;
    assign rate_valid = rate_valid_reg;

    `SWSE_ASSERT_IMPLIES(a_div_done_in_div, clk, rst_n, div_st.done, state_reg == S_DIV)
    `SWSE_ASSERT_IMPLIES(a_invalid_is_zero, clk, rst_n, out_valid && !rate_valid, rise_rate == '0)
    `SWSE_ASSERT_IMPLIES(a_issue_bound, clk, rst_n, state_reg == S_ACC, issue_reg <= n_reg)
    `SWSE_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && !in_stall, state_reg != S_IDLE)

endmodule

// File: hw/rtl/swse_mem.sv
module swse_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 20
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/swse_div.sv
module swse_div #(
    parameter int DVD_W = 49,
    parameter int DVS_W = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DVD_W-1:0]         dividend,
    input  logic [DVS_W-1:0]         divisor,
    output logic [DVD_W-1:0]         quotient,
    output swse_pkg::div_status_t    status
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] diff;
    logic           take;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        take   = (rem_sh >= {1'b0, dvs_reg});
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= take ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                dvd_reg <= dvd_reg << 1;
                quo_reg <= {quo_reg[DVD_W-2:0], take};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int SENSOR_W      = swse_pkg::SENSOR_W;
    localparam int TEMP_W        = swse_pkg::TEMP_W;
    localparam int RATE_W        = swse_pkg::RATE_W;
    localparam int COUNT_W       = swse_pkg::COUNT_W;
    localparam int FRAC_BITS_DEF = swse_pkg::FRAC_BITS_DEF;

    localparam int NSENS = swse_pkg::SENSORS_DEF;
    localparam int HMAX  = swse_pkg::HISTORY_MAX_DEF;
    localparam int DRAIN_CYCLES = 120;

    // One expected result beat
    typedef struct {
        logic [SENSOR_W-1:0]      sensor;
        logic signed [RATE_W-1:0] rate;
        logic                     valid;
    } rate_beat_t;

    logic clk;
    logic rst_n;
    logic history_count_we;
    logic [COUNT_W-1:0] history_count;
    logic in_valid;
    logic in_stall;
    logic [SENSOR_W-1:0] sensor;
    logic signed [TEMP_W-1:0] temperature;
    logic out_valid;
    logic out_stall;
    logic [SENSOR_W-1:0] sensor_out;
    logic signed [RATE_W-1:0] rise_rate;
    logic rate_valid;

    // Shadow copy of the block's per-sensor rings and window setting
    logic signed [TEMP_W-1:0] ring_mem [NSENS][HMAX];
    int unsigned ring_fill [NSENS];
    int unsigned ring_head [NSENS];
    int unsigned window_setting;

    rate_beat_t pending_rates[$];
    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int beats_sent;
    int beats_checked;
    int valid_rates;

    sliding_window_slope_estimator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .history_count_we (history_count_we),
        .history_count    (history_count),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sensor           (sensor),
        .temperature      (temperature),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sensor_out       (sensor_out),
        .rise_rate        (rise_rate),
        .rate_valid       (rate_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #20_000_000;
        $display("sliding_window_slope_estimator: mismatch");
        $finish;
    end

    // Store a sample in the shadow rings and fit the least-squares slope over the
    // newest N samples; return the rate beat the block should produce.
    function automatic rate_beat_t fit_slope(input logic [SENSOR_W-1:0] s,
                                             input logic signed [TEMP_W-1:0] t);
        rate_beat_t  r;
        int unsigned n;
        int unsigned slot;
        longint sx, sy, sxx, sxy, x, y, num, den;
        longint unsigned an, ad, q;
        logic neg;
        r.sensor = s;
        r.rate   = '0;
        r.valid  = 1'b0;
        n = window_setting;
        if (n <= 1)
            return r;
        if (n > HMAX)
            n = HMAX;
        // advance the ring and drop the oldest when the window shrank
        ring_head[s] = (ring_head[s] + 1) % HMAX;
        ring_mem[s][ring_head[s]] = t;
        if (ring_fill[s] < n)
            ring_fill[s]++;
        else
            ring_fill[s] = n;
        if (ring_fill[s] < n)
            return r;
        sx = 0; sy = 0; sxx = 0; sxy = 0;
        for (int i = 0; i < n; i++)
        begin
            slot = (ring_head[s] + HMAX - i) % HMAX;
            y = longint'(ring_mem[s][slot]);
            x = -5 * i;
            sx += x;
            sy += y;
            sxx += x * x;
            sxy += x * y;
        end
        den = longint'(n) * sxx - sx * sx;
        num = longint'(n) * sxy - sx * sy;
        if (den == 0)
            return r;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? longint'(-num) : num;
        ad = (den < 0) ? longint'(-den) : den;
        q = (an * 60 * (64'd1 << FRAC_BITS_DEF)) / ad;
        // saturate to the 40-bit signed range
        if (neg)
        begin
            if (q > (64'd1 << (RATE_W - 1)))
                q = 64'd1 << (RATE_W - 1);
            r.rate = RATE_W'(-q);
        end
        else
        begin
            if (q > (64'd1 << (RATE_W - 1)) - 1)
                q = (64'd1 << (RATE_W - 1)) - 1;
            r.rate = RATE_W'(q);
        end
        r.valid = 1'b1;
        return r;
    endfunction

    // Receiver: stall at random per the current idle rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        rate_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rates.size() == 0)
            begin
                $error("unexpected result beat: sensor_out=%0d", sensor_out);
                fail_count++;
            end
            else
            begin
                e = pending_rates[0];
                pending_rates.delete(0);
                beats_checked++;
                if (rate_valid === 1'b1)
                    valid_rates++;
                if (sensor_out !== e.sensor)
                begin
                    $error("sensor_out: expected %0d, got %0d", e.sensor, sensor_out);
                    fail_count++;
                end
                if (rise_rate !== e.rate)
                begin
                    $error("rise_rate: expected %0d, got %0d", e.rate, rise_rate);
                    fail_count++;
                end
                if (rate_valid !== e.valid)
                begin
                    $error("rate_valid: expected %0d, got %0d", e.valid, rate_valid);
                    fail_count++;
                end
            end
        end
    end

    // Send one sample beat; valid stays high across back-to-back beats and drops
    // only on idle cycles, so it is never lowered and raised in the same step.
    task automatic send_sample(input logic [SENSOR_W-1:0] s, input logic signed [TEMP_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sensor      <= s;
        temperature <= t;
        // stall is stable by the falling edge; the next rising edge takes the beat
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        pending_rates.insert(pending_rates.size(), fit_slope(s, t));
        beats_sent++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for the block to drain, then write the window length
    task automatic set_window(input int unsigned n);
        drop_valid();
        while (pending_rates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        history_count_we <= 1'b1;
        history_count    <= COUNT_W'(n);
        @(posedge clk);
        history_count_we <= 1'b0;
        window_setting = n;
    endtask

    // Tracking off: N of 0 and 1 store nothing and never report a rate
    task automatic test_tracking_off();
        set_window(0);
        send_sample(0, 20'sh7FFFF);
        send_sample(15, -20'sd524288);
        set_window(1);
        send_sample(0, 20'sd0);
        send_sample(15, 20'sh55555);
    endtask

    // Short windows at the field extremes: largest and smallest slopes
    task automatic test_extremes();
        set_window(2);
        send_sample(1, -20'sd524288);
        send_sample(1, 20'sd524287);
        send_sample(1, -20'sd524288);
        send_sample(14, 20'sd0);
        send_sample(14, -20'sd1);
        send_sample(14, -20'sd1);
    endtask

    // Full-depth window, then a count above capacity that must saturate to 16
    task automatic test_full_depth();
        set_window(HMAX);
        for (int i = 0; i < HMAX; i++)
            send_sample(2, TEMP_W'(i * 1000 - 7000));
        set_window(31);
        send_sample(2, 20'sd524287);
    endtask

    // Lower the count: the fill clamps and the window keeps the newest samples
    task automatic test_window_shrink();
        set_window(3);
        send_sample(2, 20'sd12345);
        send_sample(2, -20'sd999);
    endtask

    // Random phase: mostly smooth trends on a few sensors so windows fill,
    // with some full-range noise and occasional other sensors
    task automatic test_random_phase(input int snd, input int rcv, input int items);
        int unsigned choices [9] = '{2, 3, 4, 5, 8, 12, 16, 20, 31};
        int unsigned sel;
        logic [SENSOR_W-1:0] s;
        logic signed [TEMP_W-1:0] t;
        longint base [NSENS];
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        for (int k = 0; k < NSENS; k++)
            base[k] = longint'($urandom_range(200000)) - 100000;
        for (int i = 0; i < items; i++)
        begin
            if (i % 130 == 0)
            begin
                sel = $urandom_range(10);
                set_window(sel < 9 ? choices[sel] : sel - 9);
            end
            s = ($urandom_range(9) == 0) ? SENSOR_W'($urandom_range(15))
                                         : SENSOR_W'($urandom_range(3));
            if ($urandom_range(4) == 0)
                t = TEMP_W'($urandom);
            else
            begin
                // advance a drifting trend with a little jitter
                base[s] += longint'($urandom_range(2000)) - 1000;
                if (base[s] > 500000 || base[s] < -500000)
                    base[s] = 0;
                t = TEMP_W'(base[s] + longint'($urandom_range(64)) - 32);
            end
            send_sample(s, t);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        history_count_we = 1'b0;
        history_count    = '0;
        in_valid         = 1'b0;
        sensor           = '0;
        temperature      = '0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        fail_count       = 0;
        beats_sent       = 0;
        beats_checked    = 0;
        valid_rates      = 0;
        window_setting   = 0;
        for (int k = 0; k < NSENS; k++)
        begin
            ring_fill[k] = 0;
            ring_head[k] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tracking_off();
        test_extremes();
        test_full_depth();
        test_window_shrink();
        test_random_phase(21, 55, 650);
        test_random_phase(55, 21, 650);
        test_random_phase(0, 0, 650);

        drop_valid();
        while (pending_rates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sample beats, %0d results checked, %0d with a valid rate,",
                 beats_sent, beats_checked, valid_rates);
        $display("window lengths 0..31 under sender and receiver stalls.");
        if (fail_count == 0)
            $display("sliding_window_slope_estimator: match");
        else
            $display("sliding_window_slope_estimator: mismatch");
        $finish;
    end

endmodule

// File: sliding_window_slope_estimator.f
+incdir+hw/rtl
hw/rtl/swse_pkg.sv
hw/rtl/swse_mem.sv
hw/rtl/swse_div.sv
hw/rtl/sliding_window_slope_estimator.sv
verif/tb_top.sv
